// ===== design/llx_pkg.sv =====
// Shared types, constants and next-state function of the literal lexer.
package llx_pkg;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_E_LO   = 8'h65;
   localparam logic [7:0] CHAR_E_UP   = 8'h45;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_APOS   = 8'h27;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_ERROR    = 2'd1;
   localparam logic [1:0] STATUS_ENDED    = 2'd2;

   localparam logic MODE_NUMBER = 1'b0;
   localparam logic MODE_STRING = 1'b1;

   // number lexer states
   localparam logic [2:0] NUM_BEGIN        = 3'd0;
   localparam logic [2:0] NUM_INTEGER      = 3'd1;
   localparam logic [2:0] NUM_BEGIN_DEC    = 3'd2;
   localparam logic [2:0] NUM_DECIMAL      = 3'd3;
   localparam logic [2:0] NUM_BEGIN_EXP    = 3'd4;
   localparam logic [2:0] NUM_BEGIN_SEXP   = 3'd5;
   localparam logic [2:0] NUM_DEC_WITH_EXP = 3'd6;

   // string lexer states
   localparam logic [2:0] STR_BEGIN       = 3'd0;
   localparam logic [2:0] STR_STRING      = 3'd1;
   localparam logic [2:0] STR_ESCAPE      = 3'd2;
   localparam logic [2:0] STR_BAD_ESC     = 3'd3;
   localparam logic [2:0] STR_END         = 3'd4;
   localparam logic [2:0] STR_BAD_ESC_END = 3'd5;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] char_in;
      logic [7:0] lookahead_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] error_position;
      logic [15:0] token_length;
      logic [2:0]  final_state;
   } rsp_type;

   typedef struct packed {
      logic is_digit;
      logic is_e;
      logic is_dot;
      logic la_dot;
      logic is_sign;
      logic is_quote;
      logic is_bslash;
      logic is_nl;
      logic is_esc;
      logic is_last;
   } char_class_type;

   typedef struct packed {
      logic       valid;
      char_class_type cls;
   } queue_beat_type;

   typedef struct packed {
      logic       stop;
      logic       err;
      logic [2:0] nx;
   } step_type;

   // class of the newline appended at the end of a run (lookahead 0)
   localparam char_class_type NL_CLASS = '{
      is_digit: 1'b0, is_e: 1'b0, is_dot: 1'b0, la_dot: 1'b0, is_sign: 1'b0,
      is_quote: 1'b0, is_bslash: 1'b0, is_nl: 1'b1, is_esc: 1'b0, is_last: 1'b1};

   function automatic step_type lex_next(input logic mode, input logic [2:0] st,
                                         input char_class_type c);
      step_type r;
      r = '{stop: 1'b1, err: 1'b0, nx: st};
      if (mode == MODE_NUMBER) begin
         case (st)
            NUM_BEGIN: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_INTEGER};
               else r.err = 1'b1;
            end
            NUM_INTEGER: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_INTEGER};
               else if (c.is_dot) begin
                  if (!c.la_dot) r = '{1'b0, 1'b0, NUM_BEGIN_DEC};
               end else if (c.is_e) r = '{1'b0, 1'b0, NUM_BEGIN_EXP};
            end
            NUM_BEGIN_DEC: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_DECIMAL};
               else r.err = 1'b1;
            end
            NUM_DECIMAL: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_DECIMAL};
               else if (c.is_e) r = '{1'b0, 1'b0, NUM_BEGIN_EXP};
            end
            NUM_BEGIN_EXP: begin
               if (c.is_sign) r = '{1'b0, 1'b0, NUM_BEGIN_SEXP};
               else if (c.is_digit) r = '{1'b0, 1'b0, NUM_DEC_WITH_EXP};
               else r.err = 1'b1;
            end
            NUM_BEGIN_SEXP: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_DEC_WITH_EXP};
               else r.err = 1'b1;
            end
            NUM_DEC_WITH_EXP: begin
               if (c.is_digit) r = '{1'b0, 1'b0, NUM_DEC_WITH_EXP};
            end
            default: r.err = 1'b1;
         endcase
      end else begin
         case (st)
            STR_BEGIN: begin
               if (c.is_quote) r = '{1'b0, 1'b0, STR_STRING};
               else r.err = 1'b1;
            end
            STR_STRING: begin
               if (c.is_bslash) r = '{1'b0, 1'b0, STR_ESCAPE};
               else if (c.is_nl) r.err = 1'b1;
               else if (c.is_quote) r = '{1'b0, 1'b0, STR_END};
               else r = '{1'b0, 1'b0, STR_STRING};
            end
            STR_ESCAPE: begin
               if (c.is_esc) r = '{1'b0, 1'b0, STR_STRING};
               else r = '{1'b0, 1'b1, STR_BAD_ESC};
            end
            STR_BAD_ESC: begin
               if (c.is_nl) r.err = 1'b1;
               else if (c.is_quote) r = '{1'b0, 1'b0, STR_BAD_ESC_END};
               else r = '{1'b0, 1'b0, STR_BAD_ESC};
            end
            STR_END: r.stop = 1'b1;
            default: r.err = 1'b1;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== design/llx_front.sv =====
// Front end: accepts request beats and classifies the characters.
module llx_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  llx_pkg::req_type      req_data,
   input  logic                  q_full,
   output llx_pkg::queue_beat_type q_push
);
   import llx_pkg::*;

   char_class_type cls;

   always_comb begin
      cls.is_digit  = (req_data.char_in >= CHAR_ZERO) && (req_data.char_in <= CHAR_NINE);
      cls.is_e      = (req_data.char_in == CHAR_E_LO) || (req_data.char_in == CHAR_E_UP);
      cls.is_dot    = (req_data.char_in == CHAR_DOT);
      cls.la_dot    = (req_data.lookahead_char == CHAR_DOT);
      cls.is_sign   = (req_data.char_in == CHAR_PLUS) || (req_data.char_in == CHAR_MINUS);
      cls.is_quote  = (req_data.char_in == CHAR_QUOTE);
      cls.is_bslash = (req_data.char_in == CHAR_BSLASH);
      cls.is_nl     = (req_data.char_in == CHAR_NL);
      cls.is_esc    = (req_data.char_in == CHAR_ZERO)  || (req_data.char_in == CHAR_BSLASH) ||
                      (req_data.char_in == CHAR_T)     || (req_data.char_in == CHAR_N)      ||
                      (req_data.char_in == CHAR_R)     || (req_data.char_in == CHAR_QUOTE)  ||
                      (req_data.char_in == CHAR_APOS);
      cls.is_last   = req_data.is_last;
   end

   assign req_stall    = q_full;
   assign q_push.valid = req_valid && !q_full;
   assign q_push.cls   = cls;

endmodule

// ===== design/llx_queue.sv =====
// Short queue of classified beats between front end and lexer back end.
module llx_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  llx_pkg::queue_beat_type q_push,
   output logic                    q_full,
   output llx_pkg::queue_beat_type q_head,
   input  logic                    q_pop
);
   import llx_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   char_class_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign q_full       = (count_ff == CNT_FULL);
   assign q_head.valid = (count_ff != '0);
   assign q_head.cls   = entry_ff[rd_ptr_ff];
   assign do_pop       = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.cls;
      end
   end

endmodule

// ===== design/llx_back.sv =====
// Back end: lexer state machine, position tracking and result register.
module llx_back #(
   parameter int POSITION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic                    csr_lexer_mode,
   input  llx_pkg::queue_beat_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output llx_pkg::rsp_type        rsp_data
);
   import llx_pkg::*;

   localparam int EXT_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic                     mode_ff, mode_in;
   logic [2:0]               st_ff, st_in;
   logic                     es_ff, es_in;
   logic [POSITION_BITS-1:0] fei_ff, fei_in;
   logic [POSITION_BITS-1:0] idx_ff, idx_in;
   logic                     fin_ff, fin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   step_type                 s1, s2;
   logic                     es1, es2;
   logic [POSITION_BITS-1:0] fei1, fei2, idx1, idx2;
   logic [EXT_W-1:0]         ext_fei1, ext_fei2, ext_idx0, ext_idx1, ext_idx2;
   logic                     res_valid;
   rsp_type                  res;
   logic                     clear;

   assign q_pop = q_head.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      s1   = lex_next(mode_ff, st_ff, q_head.cls);
      es1  = es_ff || s1.err;
      fei1 = (s1.err && !es_ff) ? idx_ff : fei_ff;
      idx1 = (idx_ff == POS_MAX) ? idx_ff : idx_ff + 1'b1;
      s2   = lex_next(mode_ff, s1.nx, NL_CLASS);
      es2  = es1 || s2.err;
      fei2 = (s2.err && !es1) ? idx1 : fei1;
      idx2 = (idx1 == POS_MAX) ? idx1 : idx1 + 1'b1;
      ext_fei1 = EXT_W'(fei1);
      ext_fei2 = EXT_W'(fei2);
      ext_idx0 = EXT_W'(idx_ff);
      ext_idx1 = EXT_W'(idx1);
      ext_idx2 = EXT_W'(idx2);
   end

   always_comb begin
      st_in     = st_ff;
      es_in     = es_ff;
      fei_in    = fei_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      res_valid = 1'b0;
      res       = '0;
      clear     = 1'b0;
      if (q_pop) begin
         if (fin_ff) begin
            clear = q_head.cls.is_last;
         end else if (s1.stop) begin
            res_valid          = 1'b1;
            res.status         = es1 ? STATUS_ERROR : STATUS_ACCEPTED;
            res.error_position = es1 ? ext_fei1[15:0] : 16'd0;
            res.token_length   = ext_idx0[15:0];
            res.final_state    = st_ff;
            clear              = q_head.cls.is_last;
            fin_in             = 1'b1;
         end else if (!q_head.cls.is_last) begin
            st_in  = s1.nx;
            es_in  = es1;
            fei_in = fei1;
            idx_in = idx1;
         end else begin
            // run ends mid-token: lex an appended newline unless one was just seen
            res_valid = 1'b1;
            clear     = 1'b1;
            if (!q_head.cls.is_nl && s2.stop) begin
               res.status         = es2 ? STATUS_ERROR : STATUS_ACCEPTED;
               res.error_position = es2 ? ext_fei2[15:0] : 16'd0;
               res.token_length   = ext_idx1[15:0];
               res.final_state    = s1.nx;
            end else if (!q_head.cls.is_nl) begin
               res.status         = STATUS_ENDED;
               res.error_position = 16'd0;
               res.token_length   = ext_idx2[15:0];
               res.final_state    = s2.nx;
            end else begin
               res.status         = STATUS_ENDED;
               res.error_position = 16'd0;
               res.token_length   = ext_idx1[15:0];
               res.final_state    = s1.nx;
            end
         end
         if (clear) begin
            st_in  = NUM_BEGIN;
            es_in  = 1'b0;
            fei_in = '0;
            idx_in = '0;
            fin_in = 1'b0;
         end
      end
   end

   assign mode_in      = csr_write ? csr_lexer_mode : mode_ff;
   assign rsp_valid_in = q_pop ? res_valid : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (q_pop && res_valid) ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NUMBER;
         st_ff        <= NUM_BEGIN;
         es_ff        <= 1'b0;
         fei_ff       <= '0;
         idx_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         st_ff        <= st_in;
         es_ff        <= es_in;
         fei_ff       <= fei_in;
         idx_ff       <= idx_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/literal_lexer_fsm_unit.sv =====
// Literal lexer: one character per beat, accepted at up to one beat per clock. A beat is
// classified on entry, waits in a two-entry queue and is stepped through the lexer state
// machine at one character per cycle unless a stalled result holds it; the last beat of
// a run may also step an appended newline. The character that ends the token is registered
// in the queue, and its result in an output register where it is held, so up to two
// more beats are still taken while a result is stalled. At most one result per token;
// characters after a result are dropped up to is_last. csr writes set the number or string
// mode and are taken at once.
module literal_lexer_fsm_unit #(
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  llx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output llx_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_lexer_mode
);
   import llx_pkg::*;

   queue_beat_type q_push;
   queue_beat_type q_head;
   logic           q_full;
   logic           q_pop;

   assign csr_ready = 1'b1;

   llx_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   llx_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   llx_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_lexer_mode (csr_lexer_mode),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

// ===== design/llx_checker.sv =====
// Port-level assertions for the literal lexer and their bind to the top level.
module llx_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input llx_pkg::rsp_type rsp_data
);
   import llx_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_epos_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_ERROR) |-> rsp_data.error_position == 16'd0)
      else $error("error position set without an error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_ACCEPTED) || (rsp_data.status == STATUS_ERROR) ||
                    (rsp_data.status == STATUS_ENDED))
      else $error("unknown status code");

   a_epos_below_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ERROR) |->
         rsp_data.error_position <= rsp_data.token_length)
      else $error("error position beyond token length");

endmodule

bind literal_lexer_fsm_unit llx_checker u_llx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/tb_literal_lexer_fsm_unit.sv =====
// Self-checking testbench for the literal lexer: directed tokens, a long string, random runs.
`timescale 1ns / 1ps

module tb_literal_lexer_fsm_unit;
   import llx_pkg::*;

   localparam int LEX_HALT       = -1;
   localparam int RANDOM_ITEMS   = 650;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int FILL_CHARS     = 40;
   localparam int MAX_PRINTS     = 100;

   class lexer_scoreboard;
      logic        mode;
      logic [2:0]  state;
      logic        err_seen;
      logic [15:0] first_err;
      logic [15:0] pos;
      logic        done;
      rsp_type     token_results[$];
      int          mismatches;

      function new();
         mode = MODE_NUMBER;
         mismatches = 0;
         clear_token();
      endfunction

      function void clear_token();
         state = NUM_BEGIN;
         err_seen = 1'b0;
         first_err = '0;
         pos = '0;
         done = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function int next_number_state(logic [2:0] s, logic [7:0] c, logic [7:0] la,
                                     output bit err);
         bit d;
         bit e;
         err = 1'b0;
         d = is_digit(c);
         e = (c == CHAR_E_LO) || (c == CHAR_E_UP);
         case (s)
            NUM_BEGIN: begin
               if (d) return NUM_INTEGER;
               err = 1'b1;
               return LEX_HALT;
            end
            NUM_INTEGER: begin
               if (d) return NUM_INTEGER;
               if (c == CHAR_DOT) return (la == CHAR_DOT) ? LEX_HALT : NUM_BEGIN_DEC;
               if (e) return NUM_BEGIN_EXP;
               return LEX_HALT;
            end
            NUM_BEGIN_DEC: begin
               if (d) return NUM_DECIMAL;
               err = 1'b1;
               return LEX_HALT;
            end
            NUM_DECIMAL: begin
               if (d) return NUM_DECIMAL;
               if (e) return NUM_BEGIN_EXP;
               return LEX_HALT;
            end
            NUM_BEGIN_EXP: begin
               if (c == CHAR_PLUS || c == CHAR_MINUS) return NUM_BEGIN_SEXP;
               if (d) return NUM_DEC_WITH_EXP;
               err = 1'b1;
               return LEX_HALT;
            end
            NUM_BEGIN_SEXP: begin
               if (d) return NUM_DEC_WITH_EXP;
               err = 1'b1;
               return LEX_HALT;
            end
            NUM_DEC_WITH_EXP: begin
               if (d) return NUM_DEC_WITH_EXP;
               return LEX_HALT;
            end
            default: begin
               err = 1'b1;
               return LEX_HALT;
            end
         endcase
      endfunction

      function int next_string_state(logic [2:0] s, logic [7:0] c, output bit err);
         err = 1'b0;
         case (s)
            STR_BEGIN: begin
               if (c == CHAR_QUOTE) return STR_STRING;
               err = 1'b1;
               return LEX_HALT;
            end
            STR_STRING: begin
               if (c == CHAR_BSLASH) return STR_ESCAPE;
               if (c == CHAR_NL) begin
                  err = 1'b1;
                  return LEX_HALT;
               end
               if (c == CHAR_QUOTE) return STR_END;
               return STR_STRING;
            end
            STR_ESCAPE: begin
               if (c == CHAR_ZERO || c == CHAR_BSLASH || c == CHAR_T || c == CHAR_N ||
                   c == CHAR_R || c == CHAR_QUOTE || c == CHAR_APOS)
                  return STR_STRING;
               err = 1'b1;
               return STR_BAD_ESC;
            end
            STR_BAD_ESC: begin
               if (c == CHAR_NL) begin
                  err = 1'b1;
                  return LEX_HALT;
               end
               if (c == CHAR_QUOTE) return STR_BAD_ESC_END;
               return STR_BAD_ESC;
            end
            STR_END: return LEX_HALT;
            default: begin
               err = 1'b1;
               return LEX_HALT;
            end
         endcase
      endfunction

      // one lexer step; queues the token result when the token terminates
      function bit advance_lexer(logic [7:0] c, logic [7:0] la);
         bit      err;
         int      nx;
         rsp_type r;
         if (mode == MODE_STRING) nx = next_string_state(state, c, err);
         else nx = next_number_state(state, c, la, err);
         if (err && !err_seen) begin
            err_seen = 1'b1;
            first_err = pos;
         end
         if (nx == LEX_HALT) begin
            r.status = err_seen ? STATUS_ERROR : STATUS_ACCEPTED;
            r.error_position = err_seen ? first_err : 16'd0;
            r.token_length = pos;
            r.final_state = state;
            token_results.push_back(r);
            return 1'b1;
         end
         state = nx[2:0];
         if (pos != 16'hFFFF) pos++;
         return 1'b0;
      endfunction

      function void note_char(req_type b);
         rsp_type r;
         if (done) begin
            if (b.is_last) clear_token();
            return;
         end
         if (advance_lexer(b.char_in, b.lookahead_char)) begin
            if (b.is_last) clear_token();
            else done = 1'b1;
            return;
         end
         if (!b.is_last) return;
         if (b.char_in != CHAR_NL && advance_lexer(CHAR_NL, 8'h00)) begin
            clear_token();
            return;
         end
         r.status = STATUS_ENDED;
         r.error_position = 16'd0;
         r.token_length = pos;
         r.final_state = state;
         token_results.push_back(r);
         clear_token();
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_token(rsp_type r);
         rsp_type e;
         if (token_results.size() == 0) begin
            report($sformatf("result %h with none outstanding", r));
            return;
         end
         e = token_results.pop_front();
         if (r.status !== e.status)
            report($sformatf("status %0d, want %0d", r.status, e.status));
         if (r.error_position !== e.error_position)
            report($sformatf("error_position %0d, want %0d", r.error_position,
                             e.error_position));
         if (r.token_length !== e.token_length)
            report($sformatf("token_length %0d, want %0d", r.token_length, e.token_length));
         if (r.final_state !== e.final_state)
            report($sformatf("final_state %0d, want %0d", r.final_state, e.final_state));
      endtask

      task close_out();
         if (token_results.size() != 0)
            report($sformatf("%0d results never arrived", token_results.size()));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_lexer_mode = 1'b0;

   logic    steady = 1'b0;
   int      quiet_cycles = 0;
   logic [7:0] run_q[$];

   lexer_scoreboard sb = new();

   literal_lexer_fsm_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_lexer_mode (csr_lexer_mode)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 24);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_char(req_data);
         if (rsp_valid && !rsp_stall) sb.check_token(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic [7:0] la, input logic last);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{char_in: c, lookahead_char: la, is_last: last};
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_text(input string s, input logic close);
      logic [7:0] la;
      for (int i = 0; i < s.len(); i++) begin
         la = (i + 1 < s.len()) ? s[i + 1] : 8'h00;
         send_char(s[i], la, close && (i == s.len() - 1));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.token_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid <= 1'b1;
      csr_lexer_mode <= m;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      sb.mode = m;
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126));
      while (c == CHAR_QUOTE || c == CHAR_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] rand_escape();
      case ($urandom_range(0, 6))
         0: return CHAR_ZERO;
         1: return CHAR_BSLASH;
         2: return CHAR_T;
         3: return CHAR_N;
         4: return CHAR_R;
         5: return CHAR_QUOTE;
         default: return CHAR_APOS;
      endcase
   endfunction

   task automatic build_number_run();
      run_q.delete();
      repeat ($urandom_range(1, 4)) run_q.push_back(rand_digit());
      if ($urandom_range(0, 2) == 0) begin
         run_q.push_back(CHAR_DOT);
         repeat ($urandom_range(1, 3)) run_q.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
         run_q.push_back($urandom_range(0, 1) ? CHAR_E_LO : CHAR_E_UP);
         if ($urandom_range(0, 1)) run_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
         repeat ($urandom_range(1, 3)) run_q.push_back(rand_digit());
      end
      case ($urandom_range(0, 3))
         0: ;
         1: run_q.push_back(CHAR_NL);
         2: run_q.push_back(rand_byte());
         default: begin
            run_q.push_back(CHAR_DOT);
            run_q.push_back(CHAR_DOT);
         end
      endcase
      repeat ($urandom_range(0, 2)) run_q.push_back(rand_byte());
   endtask

   task automatic build_string_run();
      run_q.delete();
      run_q.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(0, 3) == 0) begin
            run_q.push_back(CHAR_BSLASH);
            run_q.push_back(($urandom_range(0, 3) == 0) ? rand_byte() : rand_escape());
         end else begin
            run_q.push_back(rand_plain());
         end
      end
      case ($urandom_range(0, 5))
         0, 1: run_q.push_back(CHAR_QUOTE);
         2, 3: begin
            run_q.push_back(CHAR_QUOTE);
            run_q.push_back($urandom_range(0, 1) ? rand_plain() : rand_byte());
         end
         4: ;
         default: run_q.push_back(CHAR_NL);
      endcase
      repeat ($urandom_range(0, 2)) run_q.push_back(rand_byte());
   endtask

   task automatic send_run();
      logic [7:0] la;
      for (int i = 0; i < run_q.size(); i++) begin
         la = (i + 1 < run_q.size()) ? run_q[i + 1] : rand_byte();
         if ($urandom_range(0, 19) == 0) la = rand_byte();
         send_char(run_q[i], la, i == run_q.size() - 1);
      end
   endtask

   initial begin
      int   items;
      int   phase;
      int   kind;
      logic m;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed tokens
      write_mode(MODE_NUMBER);
      send_char(8'hFF, 8'h00, 1'b1);
      send_text("1.5E+3", 1'b1);
      send_text("1..", 1'b1);
      send_text("3e", 1'b1);
      send_text("12", 1'b0);
      drain();
      write_mode(MODE_STRING);
      send_text("\"", 1'b1);
      send_text("\"\\q\".", 1'b1);
      send_text("\"\\", 1'b1);
      send_char(8'h00, 8'hFF, 1'b1);
      drain();
      write_mode(MODE_NUMBER);
      send_text("1e5", 1'b0);
      drain();
      write_mode(MODE_STRING);
      send_text("z", 1'b1);
      drain();

      // long string, back to back, with a bad escape late in the token
      write_mode(MODE_STRING);
      steady <= 1'b1;
      send_char(CHAR_QUOTE, rand_byte(), 1'b0);
      for (int k = 0; k < FILL_CHARS; k++)
         send_char(8'($urandom_range(8'h61, 8'h7A)), rand_byte(), 1'b0);
      send_char(CHAR_BSLASH, rand_byte(), 1'b0);
      send_char(8'h78, rand_byte(), 1'b0);
      send_char(CHAR_QUOTE, rand_byte(), 1'b0);
      send_char(8'h7A, rand_byte(), 1'b0);
      send_char(8'h71, rand_byte(), 1'b1);
      steady <= 1'b0;
      drain();

      // random runs, mode changed between phases
      items = 0;
      phase = 0;
      while (items < RANDOM_ITEMS) begin
         m = (phase == 0) ? MODE_NUMBER : (phase == 1) ? MODE_STRING : 1'($urandom_range(0, 1));
         write_mode(m);
         steady <= (phase == 2);
         repeat ($urandom_range(4, 12)) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
               run_q.delete();
               repeat ($urandom_range(1, 6)) run_q.push_back(rand_byte());
            end else if ((kind < 7) == (m == MODE_STRING)) begin
               build_string_run();
            end else begin
               build_number_run();
            end
            if ($urandom_range(0, 3) == 0)
               foreach (run_q[i]) if ($urandom_range(0, 9) == 0) run_q[i] = rand_byte();
            send_run();
            items += run_q.size();
         end
         drain();
         steady <= 1'b0;
         phase++;
      end

      drain();
      sb.close_out();
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
